FILE: sv/aarm_pkg.sv
// Shared types, constants and arithmetic helpers for the axis-angle rotation matrix unit.
// Used by every module of the block; depends on nothing else.
package aarm_pkg;

    // Default and upper bound of the CORDIC stage count
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CORDIC_MAX        = 32;

    // CORDIC datapath width (Q2.30 plus headroom)
    localparam int AW = 34;
    localparam logic signed [AW-1:0] INV_GAIN = 34'sh026DD3B6A;

    // Angle constants in Q16.16 degrees
    localparam int DEG_FULL    = 360 * 65536;
    localparam int DEG_HALF    = 180 * 65536;
    localparam int DEG_QUARTER = 90 * 65536;
    // Whole turns added so that any 32-bit angle becomes non-negative
    localparam int WRAP_TURNS  = 92;
    localparam logic [32:0] ANGLE_BIAS = 33'(64'(WRAP_TURNS) * 64'(DEG_FULL));

    // pi/180 in Q.38, split into two partial products
    localparam logic [63:0] DEG_TO_RAD_Q38 = 64'd4797524517;
    localparam int RAD_LO_BITS = 17;
    localparam logic [15:0] RAD_HI = 16'(DEG_TO_RAD_Q38 >> RAD_LO_BITS);
    localparam logic [16:0] RAD_LO = 17'(DEG_TO_RAD_Q38);

    localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

    // Pipeline step counts
    localparam int MOD_STEPS  = 8;
    localparam int NORM_STEPS = 5;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    // Register depth of the axis path up to the signed unit vector
    localparam int AXIS_DEPTH = 2 + NORM_STEPS + 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    // Adds the two product stages and the entry stage
    localparam int PIPE_DEPTH = AXIS_DEPTH + 3;

    localparam logic [1:0] FIRST_COL = 2'd0;
    localparam logic [1:0] LAST_COL  = 2'd3;

    // Arctangent of 2^-i in Q2.30
    localparam logic [31:0] ATAN_Q30 [CORDIC_MAX] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [31:0] angle_deg;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
    } item_t;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] entry_row0;
        logic signed [31:0] entry_row1;
        logic signed [31:0] entry_row2;
        logic signed [31:0] entry_row3;
        logic               zero_axis;
        logic               last_column;
    } column_t;

    typedef struct packed {
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 negang;
        logic                 flip;
    } cordic_t;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } axis_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
        axis_t       ax;
    } sqrt_t;

    typedef struct packed {
        logic [2:0][62:0] rem;
        logic [2:0][30:0] quo;
        logic [31:0]      len;
        logic [2:0]       neg;
        logic             zero;
    } div_t;

    // Q2.30 product with rounding and floor shift
    function automatic logic signed [35:0] qmul(input logic signed [35:0] a,
                                                input logic signed [35:0] b);
        logic signed [71:0] p;
        p = a * b;
        p = p + 72'sd536870912;
        return p[65:30];
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -36'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/aarm_cordic_cell.sv
// One rotation-mode CORDIC stage with a fixed shift and arctangent.
// Depends on aarm_pkg.
module aarm_cordic_cell
    import aarm_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic    clk,
    input  logic    en,
    input  cordic_t d,
    output cordic_t q
);

    cordic_t q_reg, q_next;

    // Rotate toward zero residual angle
    always_comb
    begin
        logic signed [AW-1:0] xs, ys, at;
        xs = d.x >>> IDX;
        ys = d.y >>> IDX;
        at = $signed({2'b00, ATAN_Q30[IDX]});
        q_next = d;
        if (!d.z[AW-1])
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - at;
        end
        else
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + at;
        end
    end

    // Advance with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: sv/aarm_sqrt_cell.sv
// One digit step of the floor square root of the squared axis length.
// Depends on aarm_pkg.
module aarm_sqrt_cell
    import aarm_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  en,
    input  sqrt_t d,
    output sqrt_t q
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

    sqrt_t q_reg, q_next;

    // Try the next root bit against the remainder
    always_comb
    begin
        logic [63:0] trial;
        trial = d.root + BIT;
        q_next = d;
        if (d.rem >= trial)
        begin
            q_next.rem  = d.rem - trial;
            q_next.root = (d.root >> 1) + BIT;
        end
        else
        begin
            q_next.root = d.root >> 1;
        end
    end

    // Advance with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: sv/aarm_div_cell.sv
// One quotient bit of the three restoring divisions by the axis length.
// Depends on aarm_pkg.
module aarm_div_cell
    import aarm_pkg::*;
#(
    parameter int BITPOS = 30
)
(
    input  logic clk,
    input  logic en,
    input  div_t d,
    output div_t q
);

    div_t q_reg, q_next;

    // Subtract the shifted divisor where it fits
    always_comb
    begin
        logic [62:0] dvs;
        dvs = 63'(d.len) << BITPOS;
        q_next = d;
        for (int i = 0; i < 3; i++)
        begin
            if (d.rem[i] >= dvs)
            begin
                q_next.rem[i]         = d.rem[i] - dvs;
                q_next.quo[i][BITPOS] = 1'b1;
            end
        end
    end

    // Advance with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: sv/axis_angle_rotation_matrix_unit.sv
// Axis-angle rotation matrix unit: angle and axis in, four matrix column beats out.
// Each accepted item leaves as four column beats, one a cycle while column_stall is low.
// Item rate is set by the four column beats of each item on the single result port;
// the pipeline itself takes one item a cycle and holds only when its last stage is full while
// the column serializer is busy.
// Reset clears the valid chain and the serializer; no clearing pass. Depends on aarm_pkg and cells.
module axis_angle_rotation_matrix_unit
    import aarm_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    column_valid,
    input  logic    column_stall,
    output column_t column
);

    localparam int ANGLE_DEPTH = MOD_STEPS + 5 + CORDIC_STAGES;
    localparam int CS_DELAY    = AXIS_DEPTH - ANGLE_DEPTH;

    localparam logic signed [26:0] R_FULL    = 27'(DEG_FULL);
    localparam logic signed [26:0] R_HALF    = 27'(DEG_HALF);
    localparam logic signed [26:0] R_QUARTER = 27'(DEG_QUARTER);

    typedef struct packed {
        logic signed [AW-1:0] c;
        logic signed [AW-1:0] s;
    } trig_t;

    typedef struct packed {
        logic signed [35:0] xx, xy, xz, yy, yz, zz;
        logic signed [35:0] xs, ys, zs;
        logic signed [35:0] c;
        logic signed [35:0] t;
        logic               zero;
    } prod_t;

    typedef struct packed {
        logic signed [31:0] m0, m1, m2, m4, m5, m6, m8, m9, m10;
        logic               zero;
    } mat_t;

    // ---------------- flow control ----------------
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic                  adv, ser_free, load;
    logic                  busy_reg, busy_next;
    logic [1:0]            col_reg, col_next;

    assign ser_free   = !busy_reg || (!column_stall && col_reg == LAST_COL);
    assign adv        = !vld_reg[PIPE_DEPTH-1] || ser_free;
    assign load       = vld_reg[PIPE_DEPTH-1] && ser_free;
    assign item_stall = !adv;
    assign vld_next   = {vld_reg[PIPE_DEPTH-2:0], item_valid};

    // Shift the valid chain with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- capture stage ----------------
    item_t       item_reg;
    logic [32:0] mod_reg  [MOD_STEPS+1];
    logic [32:0] mod_next [MOD_STEPS+1];

    assign mod_next[0] = 33'(item.angle_deg) + ANGLE_BIAS;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg   <= item;
            mod_reg[0] <= mod_next[0];
        end
    end

    // ---------------- angle reduction ----------------
    for (genvar k = 0; k < MOD_STEPS; k++)
    begin : g_mod
        localparam logic [32:0] STEP = 33'(DEG_FULL) << (MOD_STEPS - 1 - k);

        assign mod_next[k+1] = (mod_reg[k] >= STEP) ? mod_reg[k] - STEP : mod_reg[k];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mod_reg[k+1] <= mod_next[k+1];
            end
        end
    end

    // Fold into [-90, 90] degrees and note the sign changes
    logic [22:0] fold_mag_reg, fold_mag_next;
    logic        fold_neg_reg, fold_neg_next;
    logic        fold_flip_reg, fold_flip_next;

    always_comb
    begin
        logic signed [26:0] r;
        r = $signed({2'b00, mod_reg[MOD_STEPS][24:0]});
        if (r >= R_HALF)
        begin
            r = r - R_FULL;
        end
        fold_flip_next = 1'b0;
        if (r > R_QUARTER)
        begin
            r = r - R_HALF;
            fold_flip_next = 1'b1;
        end
        else if (r < -R_QUARTER)
        begin
            r = r + R_HALF;
            fold_flip_next = 1'b1;
        end
        fold_neg_next = r[26];
        fold_mag_next = r[26] ? 23'(-r) : 23'(r);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fold_mag_reg  <= fold_mag_next;
            fold_neg_reg  <= fold_neg_next;
            fold_flip_reg <= fold_flip_next;
        end
    end

    // Degrees to radians: two partial products, then sum
    logic [39:0] plo_reg;
    logic [38:0] phi_reg;
    logic        p1_neg_reg, p1_flip_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plo_reg     <= 40'(fold_mag_reg) * 40'(RAD_LO);
            phi_reg     <= 39'(fold_mag_reg) * 39'(RAD_HI);
            p1_neg_reg  <= fold_neg_reg;
            p1_flip_reg <= fold_flip_reg;
        end
    end

    cordic_t cord [CORDIC_STAGES+1];
    cordic_t cord0_reg, cord0_next;

    always_comb
    begin
        logic [55:0] sum;
        sum = {phi_reg, 17'b0} + 56'(plo_reg) + (56'd1 << 23);
        cord0_next.x      = INV_GAIN;
        cord0_next.y      = '0;
        cord0_next.z      = $signed({2'b00, sum[55:24]});
        cord0_next.negang = p1_neg_reg;
        cord0_next.flip   = p1_flip_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cord0_reg <= cord0_next;
        end
    end

    assign cord[0] = cord0_reg;

    // ---------------- CORDIC chain ----------------
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        aarm_cordic_cell #(.IDX(i)) u_cell
        (
            .clk (clk),
            .en  (adv),
            .d   (cord[i]),
            .q   (cord[i+1])
        );
    end

    // Apply signs, then delay to meet the axis path
    trig_t trig_reg [CS_DELAY+1];
    trig_t trig_next;

    always_comb
    begin
        logic signed [AW-1:0] c, s;
        c = cord[CORDIC_STAGES].x;
        s = cord[CORDIC_STAGES].negang ? -cord[CORDIC_STAGES].y : cord[CORDIC_STAGES].y;
        if (cord[CORDIC_STAGES].flip)
        begin
            c = -c;
            s = -s;
        end
        trig_next.c = c;
        trig_next.s = s;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trig_reg[0] <= trig_next;
            for (int d = 0; d < CS_DELAY; d++)
            begin
                trig_reg[d+1] <= trig_reg[d];
            end
        end
    end

    // ---------------- axis magnitudes ----------------
    axis_t       ax_reg  [NORM_STEPS+1];
    axis_t       ax_next [NORM_STEPS+1];
    logic [31:0] mx_reg  [NORM_STEPS+1];
    logic [31:0] mx_next [NORM_STEPS+1];

    always_comb
    begin
        logic signed [31:0] v [3];
        v[0] = item_reg.axis_x;
        v[1] = item_reg.axis_y;
        v[2] = item_reg.axis_z;
        for (int i = 0; i < 3; i++)
        begin
            ax_next[0].neg[i] = v[i][31];
            ax_next[0].mag[i] = v[i][31] ? 32'(-v[i]) : 32'(v[i]);
        end
        ax_next[0].zero = (v[0] == '0) && (v[1] == '0) && (v[2] == '0);
        mx_next[0] = ax_next[0].mag[0];
        if (ax_next[0].mag[1] > mx_next[0])
        begin
            mx_next[0] = ax_next[0].mag[1];
        end
        if (ax_next[0].mag[2] > mx_next[0])
        begin
            mx_next[0] = ax_next[0].mag[2];
        end
    end

    // Shift all three until the largest reaches 2^30
    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        localparam int SH = (1 << (NORM_STEPS - 1)) >> j;
        localparam logic [31:0] LIMIT = 32'd1 << (31 - SH);

        always_comb
        begin
            ax_next[j+1] = ax_reg[j];
            mx_next[j+1] = mx_reg[j];
            if (mx_reg[j] < LIMIT)
            begin
                mx_next[j+1] = mx_reg[j] << SH;
                for (int i = 0; i < 3; i++)
                begin
                    ax_next[j+1].mag[i] = ax_reg[j].mag[i] << SH;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j <= NORM_STEPS; j++)
            begin
                ax_reg[j] <= ax_next[j];
                mx_reg[j] <= mx_next[j];
            end
        end
    end

    // Squares, then their sum
    logic [63:0] sq_reg [3];
    axis_t       sq_ax_reg;
    sqrt_t       sqt [SQRT_STEPS+1];
    sqrt_t       sqt0_reg, sqt0_next;

    always_comb
    begin
        sqt0_next.rem  = sq_reg[0] + sq_reg[1] + sq_reg[2];
        sqt0_next.root = '0;
        sqt0_next.ax   = sq_ax_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= 64'(ax_reg[NORM_STEPS].mag[i]) * 64'(ax_reg[NORM_STEPS].mag[i]);
            end
            sq_ax_reg <= ax_reg[NORM_STEPS];
            sqt0_reg  <= sqt0_next;
        end
    end

    assign sqt[0] = sqt0_reg;

    // ---------------- square root chain ----------------
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        aarm_sqrt_cell #(.IDX(i)) u_cell
        (
            .clk (clk),
            .en  (adv),
            .d   (sqt[i]),
            .q   (sqt[i+1])
        );
    end

    // Rounded dividends for the three components
    div_t dv [DIV_STEPS+1];
    div_t dv0_reg, dv0_next;

    always_comb
    begin
        dv0_next.len  = sqt[SQRT_STEPS].root[31:0];
        dv0_next.neg  = sqt[SQRT_STEPS].ax.neg;
        dv0_next.zero = sqt[SQRT_STEPS].ax.zero;
        dv0_next.quo  = '0;
        for (int i = 0; i < 3; i++)
        begin
            dv0_next.rem[i] = (63'(sqt[SQRT_STEPS].ax.mag[i]) << 30)
                              + 63'(dv0_next.len >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv0_reg <= dv0_next;
        end
    end

    assign dv[0] = dv0_reg;

    // ---------------- division chain ----------------
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        aarm_div_cell #(.BITPOS(DIV_STEPS - 1 - j)) u_cell
        (
            .clk (clk),
            .en  (adv),
            .d   (dv[j]),
            .q   (dv[j+1])
        );
    end

    // Restore component signs
    logic signed [31:0] n_reg [3];
    logic               n_zero_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= dv[DIV_STEPS].neg[i] ? -$signed({1'b0, dv[DIV_STEPS].quo[i]})
                                                 : $signed({1'b0, dv[DIV_STEPS].quo[i]});
            end
            n_zero_reg <= dv[DIV_STEPS].zero;
        end
    end

    // ---------------- matrix products ----------------
    prod_t pa_reg, pa_next, pb_reg, pb_next;
    mat_t  mc_reg, mc_next;

    always_comb
    begin
        logic signed [35:0] x, y, z, c, s;
        x = 36'(n_reg[0]);
        y = 36'(n_reg[1]);
        z = 36'(n_reg[2]);
        c = 36'(trig_reg[CS_DELAY].c);
        s = 36'(trig_reg[CS_DELAY].s);
        pa_next.xx   = qmul(x, x);
        pa_next.xy   = qmul(y, x);
        pa_next.xz   = qmul(x, z);
        pa_next.yy   = qmul(y, y);
        pa_next.yz   = qmul(y, z);
        pa_next.zz   = qmul(z, z);
        pa_next.xs   = qmul(x, s);
        pa_next.ys   = qmul(y, s);
        pa_next.zs   = qmul(z, s);
        pa_next.c    = c;
        pa_next.t    = ONE_Q30 - c;
        pa_next.zero = n_zero_reg;
    end

    // Scale the outer products by one minus cosine
    always_comb
    begin
        pb_next    = pa_reg;
        pb_next.xx = qmul(pa_reg.xx, pa_reg.t);
        pb_next.xy = qmul(pa_reg.xy, pa_reg.t);
        pb_next.xz = qmul(pa_reg.xz, pa_reg.t);
        pb_next.yy = qmul(pa_reg.yy, pa_reg.t);
        pb_next.yz = qmul(pa_reg.yz, pa_reg.t);
        pb_next.zz = qmul(pa_reg.zz, pa_reg.t);
    end

    // Form and clamp the entries; a zero axis gives the identity
    always_comb
    begin
        mc_next.zero = pb_reg.zero;
        if (pb_reg.zero)
        begin
            mc_next.m0  = ONE_Q30[31:0];
            mc_next.m1  = '0;
            mc_next.m2  = '0;
            mc_next.m4  = '0;
            mc_next.m5  = ONE_Q30[31:0];
            mc_next.m6  = '0;
            mc_next.m8  = '0;
            mc_next.m9  = '0;
            mc_next.m10 = ONE_Q30[31:0];
        end
        else
        begin
            mc_next.m0  = sat32(pb_reg.xx + pb_reg.c);
            mc_next.m1  = sat32(pb_reg.xy + pb_reg.zs);
            mc_next.m2  = sat32(pb_reg.xz - pb_reg.ys);
            mc_next.m4  = sat32(pb_reg.xy - pb_reg.zs);
            mc_next.m5  = sat32(pb_reg.yy + pb_reg.c);
            mc_next.m6  = sat32(pb_reg.yz + pb_reg.xs);
            mc_next.m8  = sat32(pb_reg.xz + pb_reg.ys);
            mc_next.m9  = sat32(pb_reg.yz - pb_reg.xs);
            mc_next.m10 = sat32(pb_reg.zz + pb_reg.c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            mc_reg <= mc_next;
        end
    end

    // ---------------- column serializer ----------------
    mat_t mat_reg;

    always_comb
    begin
        busy_next = busy_reg;
        col_next  = col_reg;
        if (load)
        begin
            busy_next = 1'b1;
            col_next  = FIRST_COL;
        end
        else if (busy_reg && !column_stall)
        begin
            col_next = col_reg + 2'd1;
            if (col_reg == LAST_COL)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= FIRST_COL;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
        end
    end

    // Hold the matrix while its columns drain
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mat_reg <= mc_reg;
        end
    end

    // Drive the column beat
    always_comb
    begin
        column.column_index = col_reg;
        column.zero_axis    = mat_reg.zero;
        column.last_column  = (col_reg == LAST_COL);
        unique case (col_reg)
            2'd0:
            begin
                column.entry_row0 = mat_reg.m0;
                column.entry_row1 = mat_reg.m1;
                column.entry_row2 = mat_reg.m2;
                column.entry_row3 = '0;
            end
            2'd1:
            begin
                column.entry_row0 = mat_reg.m4;
                column.entry_row1 = mat_reg.m5;
                column.entry_row2 = mat_reg.m6;
                column.entry_row3 = '0;
            end
            2'd2:
            begin
                column.entry_row0 = mat_reg.m8;
                column.entry_row1 = mat_reg.m9;
                column.entry_row2 = mat_reg.m10;
                column.entry_row3 = '0;
            end
            default:
            begin
                column.entry_row0 = '0;
                column.entry_row1 = '0;
                column.entry_row2 = '0;
                column.entry_row3 = ONE_Q30[31:0];
            end
        endcase
    end

    assign column_valid = busy_reg;

endmodule

FILE: bench/tb.sv
// Testbench for axis_angle_rotation_matrix_unit: random and directed angle/axis beats,
// predicted column beats checked in order. Depends on aarm_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;
    import aarm_pkg::*;

    localparam int STAGES   = CORDIC_STAGES_DEF;
    localparam int WD_LIMIT = 20000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    column_valid;
    logic    column_stall;
    column_t column;

    item_t   pending_items [$];
    column_t expected_cols [$];
    int      mismatches;
    int      accepted_items;
    int      checked_cols;
    int      zero_axis_items;
    int      idle_pct;
    int      stall_pct;
    bit      hold_off;
    bit      pause_sender;
    int      quiet_cycles;
    bit      timed_out;

    axis_angle_rotation_matrix_unit #(.CORDIC_STAGES(STAGES)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .column_valid (column_valid),
        .column_stall (column_stall),
        .column       (column)
    );

    // Generate clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Floor shift right of a signed value
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return floor_shr(a * b + (64'sd1 << 29), 30);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Predict the four column beats of one rotation item
    task automatic predict_rotation(input item_t it);
        longint           m [16];
        longint           v [3];
        longint unsigned  u [3];
        longint           n [3];
        longint           r, theta, cx, cy, cz, c, s, t, dx, dy, q;
        longint unsigned  mx, sum, len;
        bit               zero, flip, negang;
        column_t          col;
        for (int i = 0; i < 16; i++)
        begin
            m[i] = 0;
        end
        v[0] = it.axis_x;
        v[1] = it.axis_y;
        v[2] = it.axis_z;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = (v[i] < 0) ? -v[i] : v[i];
        end
        zero = (u[0] == 0) && (u[1] == 0) && (u[2] == 0);
        if (zero)
        begin
            m[0] = 64'sd1 << 30;
            m[5] = 64'sd1 << 30;
            m[10] = 64'sd1 << 30;
            m[15] = 64'sd1 << 30;
        end
        else
        begin
            // Reduce the angle to [-90, 90] with a sign flip
            r = longint'(it.angle_deg) % longint'(DEG_FULL);
            flip = 1'b0;
            if (r < 0) r = r + DEG_FULL;
            if (r >= DEG_HALF) r = r - DEG_FULL;
            if (r > DEG_QUARTER)
            begin
                r = r - DEG_HALF;
                flip = 1'b1;
            end
            else if (r < -DEG_QUARTER)
            begin
                r = r + DEG_HALF;
                flip = 1'b1;
            end
            negang = r < 0;
            theta = ((negang ? -r : r) * 64'sd4797524517 + (64'sd1 << 23)) >>> 24;
            // Run the rotation-mode CORDIC
            cx = 64'sh26DD3B6A;
            cy = 0;
            cz = theta;
            for (int i = 0; i < STAGES; i++)
            begin
                dx = floor_shr(cy, i);
                dy = floor_shr(cx, i);
                if (cz >= 0)
                begin
                    cx = cx - dx;
                    cy = cy + dy;
                    cz = cz - longint'(ATAN_Q30[i]);
                end
                else
                begin
                    cx = cx + dx;
                    cy = cy - dy;
                    cz = cz + longint'(ATAN_Q30[i]);
                end
            end
            c = cx;
            s = negang ? -cy : cy;
            if (flip)
            begin
                c = -c;
                s = -s;
            end
            // Normalize the axis
            mx = u[0];
            if (u[1] > mx) mx = u[1];
            if (u[2] > mx) mx = u[2];
            while (mx < (64'd1 << 30))
            begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++)
                begin
                    u[i] = u[i] << 1;
                end
            end
            sum = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
            len = floor_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = ((u[i] << 30) + len / 2) / len;
                n[i] = (v[i] < 0) ? -q : q;
            end
            t = (64'sd1 << 30) - c;
            m[0]  = q30_mul(q30_mul(n[0], n[0]), t) + c;
            m[1]  = q30_mul(q30_mul(n[1], n[0]), t) + q30_mul(n[2], s);
            m[2]  = q30_mul(q30_mul(n[0], n[2]), t) - q30_mul(n[1], s);
            m[4]  = q30_mul(q30_mul(n[0], n[1]), t) - q30_mul(n[2], s);
            m[5]  = q30_mul(q30_mul(n[1], n[1]), t) + c;
            m[6]  = q30_mul(q30_mul(n[1], n[2]), t) + q30_mul(n[0], s);
            m[8]  = q30_mul(q30_mul(n[0], n[2]), t) + q30_mul(n[1], s);
            m[9]  = q30_mul(q30_mul(n[1], n[2]), t) - q30_mul(n[0], s);
            m[10] = q30_mul(q30_mul(n[2], n[2]), t) + c;
            m[15] = 64'sd1 << 30;
        end
        for (int k = 0; k < 4; k++)
        begin
            col.column_index = 2'(k);
            col.entry_row0   = clamp32(m[k * 4]);
            col.entry_row1   = clamp32(m[k * 4 + 1]);
            col.entry_row2   = clamp32(m[k * 4 + 2]);
            col.entry_row3   = clamp32(m[k * 4 + 3]);
            col.zero_axis    = zero;
            col.last_column  = (2'(k) == LAST_COL);
            expected_cols.push_back(col);
        end
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'($urandom_range(0, 8)) - 32'd4;
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t make_item(input logic [31:0] a, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
        item_t it;
        it.angle_deg = a;
        it.axis_x    = x;
        it.axis_y    = y;
        it.axis_z    = z;
        return it;
    endfunction

    // Drive item beats from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_rotation(item);
                accepted_items = accepted_items + 1;
                void'(pending_items.pop_front());
            end
            if (item_valid && item_stall)
            begin
                // hold the stalled beat
            end
            else if (pending_items.size() != 0 &&
                     !pause_sender && $urandom_range(0, 99) >= idle_pct)
            begin
                item_valid <= 1'b1;
                item       <= pending_items[0];
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Stall the column port and check column beats
    always @(posedge clk or negedge rst_n)
    begin
        column_t exp_col;
        if (!rst_n)
        begin
            column_stall <= 1'b0;
        end
        else
        begin
            if (column_valid && !column_stall)
            begin
                checked_cols = checked_cols + 1;
                if (expected_cols.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected column beat %h", column);
                end
                else
                begin
                    exp_col = expected_cols.pop_front();
                    if (exp_col.zero_axis && exp_col.column_index == FIRST_COL)
                        zero_axis_items = zero_axis_items + 1;
                    if (column !== exp_col)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("column mismatch: expected %h, got %h", exp_col, column);
                    end
                end
            end
            column_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watch for a hang: count cycles with no beat on either port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (column_valid && !column_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drain();
        while (pending_items.size() != 0 || item_valid || expected_cols.size() != 0)
        begin
            @(posedge clk);
            if (timed_out)
                return;
        end
    endtask

    task automatic add_random(input int count);
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            a = ($urandom_range(0, 1) != 0) ? $urandom : rand_field();
            if ($urandom_range(0, 15) == 0)
                pending_items.push_back(make_item(a, 32'd0, 32'd0, 32'd0));
            else
                pending_items.push_back(make_item(a, rand_field(), rand_field(), rand_field()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        mismatches = 0;
        accepted_items = 0;
        checked_cols = 0;
        zero_axis_items = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        pause_sender = 1'b0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        item_valid = 1'b0;
        item = '0;
        column_stall = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: angle extremes, quadrant folds, zero and extreme axes
        pending_items.push_back(make_item(32'd0, 32'h00010000, 32'd0, 32'd0));
        pending_items.push_back(make_item(32'h005A0000, 32'd0, 32'h00010000, 32'd0));
        pending_items.push_back(make_item(32'hFFA60000, 32'd0, 32'd0, 32'h00010000));
        pending_items.push_back(make_item(32'h00B40000, 32'h00010000, 32'h00010000, 32'd0));
        pending_items.push_back(make_item(32'hFF4C0000, 32'd1, 32'd1, 32'd1));
        pending_items.push_back(make_item(32'h00870000, 32'hFFFFFFFF, 32'd2, 32'd0));
        pending_items.push_back(make_item(32'hFF790000, 32'd0, 32'hFFFF0000, 32'd5));
        pending_items.push_back(make_item(32'h01680000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_items.push_back(make_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
        pending_items.push_back(make_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd0));
        pending_items.push_back(make_item(32'h002D0000, 32'd0, 32'd0, 32'd0));
        pending_items.push_back(make_item(32'hFFFFFFFF, 32'd0, 32'd0, 32'hFFFFFFFF));
        pending_items.push_back(make_item(32'h00B3FFFF, 32'h12345678, 32'hEDCBA988, 32'd3));
        pending_items.push_back(make_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        drain();

        // Random phases: free run, sender idle, receiver stall, both
        idle_pct = 0;  stall_pct = 0;  add_random(4); drain();
        idle_pct = 65; stall_pct = 0;  add_random(4); drain();
        idle_pct = 0;  stall_pct = 65; add_random(4); drain();
        idle_pct = 31; stall_pct = 31; add_random(4); drain();

        // Long hold-off on the column port; more items than the pipeline holds
        idle_pct = 0;  stall_pct = 0;
        hold_off = 1'b1;
        add_random(80);
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        drain();

        // Sender pauses with beats in flight until all expected beats arrive
        add_random(4);
        while ((pending_items.size() != 0 || item_valid) && !timed_out)
        begin
            @(posedge clk);
        end
        pause_sender = 1'b1;
        drain();
        pause_sender = 1'b0;
        add_random(4);
        drain();

        repeat (100) @(posedge clk);
        $display("covered %0d items (%0d zero-axis), %0d column beats checked, %0d mismatches",
                 accepted_items, zero_axis_items, checked_cols, mismatches);
        if (mismatches == 0 && expected_cols.size() == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

    // End the run on a hang
    initial
    begin
        wait (quiet_cycles >= WD_LIMIT);
        timed_out = 1'b1;
        $display("hang: no beat for %0d cycles", WD_LIMIT);
        $display("tb: errors");
        $finish;
    end

endmodule

FILE: files.f
sv/aarm_pkg.sv
sv/aarm_cordic_cell.sv
sv/aarm_sqrt_cell.sv
sv/aarm_div_cell.sv
sv/axis_angle_rotation_matrix_unit.sv
bench/tb.sv
